// ===== rtl/core/prs_pkg.sv =====
// Shared constants, types and helpers for the polyline rule substitution block.
// No dependencies; all files but the checker import this package.
`default_nettype none

package prs_pkg;

  // field widths
  localparam int VTX_W   = 32;  // vertex coordinate, Q16.16
  localparam int RULE_W  = 18;  // rule point coordinate, Q2.16
  localparam int SLOT_W  = 4;   // rule slot index field
  localparam int RCNT_W  = 5;   // rule_count register
  localparam int FRAC_W  = 16;  // fraction bits of the output

  // datapath widths
  localparam int DIFF_W  = VTX_W + 1;          // exact vertex difference
  localparam int PROD_W  = RULE_W + DIFF_W;    // one rule * diff product
  localparam int ACC_W   = PROD_W + 1;         // sum of two products plus half lsb
  localparam int RND_W   = ACC_W - FRAC_W;     // rounded sum
  localparam int SUM_W   = RND_W + 1;          // rounded sum plus previous vertex

  // default store depth
  localparam int RULE_MAX_DEF = 16;

  // input item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_VERTEX = 1'b1;

  // product terms of the shared multiplier
  typedef enum logic [1:0] {
    TERM_XX = 2'd0,  // rx * dx, starts x
    TERM_YY = 2'd1,  // ry * dy, subtracted from x
    TERM_XY = 2'd2,  // rx * dy, starts y
    TERM_YX = 2'd3   // ry * dx, added to y
  } prs_term_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic      mul_en;
    prs_term_t mul_term;
    logic      acc_en;
    prs_term_t acc_term;
  } prs_mac_ctl_t;

  // clamp a widened sum to the signed vertex range
  function automatic logic [VTX_W-1:0] sat_vtx(input logic [SUM_W-1:0] s);
    logic [SUM_W-VTX_W:0] top;
    top = s[SUM_W-1:VTX_W-1];
    if ((&top) || (~|top)) begin
      return s[VTX_W-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, {(VTX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VTX_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prs_ifs.sv =====
// Valid/ready channel interfaces for input items and result points.
// Depends on prs_pkg for field widths.
`default_nettype none

interface prs_in_if;
  import prs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic                     start_req;
  logic [SLOT_W-1:0]        rule_slot;
  logic signed [RULE_W-1:0] rule_x;
  logic signed [RULE_W-1:0] rule_y;
  logic signed [VTX_W-1:0]  vertex_x;
  logic signed [VTX_W-1:0]  vertex_y;

  modport source (
    output valid, func, start_req, rule_slot, rule_x, rule_y, vertex_x, vertex_y,
    input  ready
  );
  modport sink (
    input  valid, func, start_req, rule_slot, rule_x, rule_y, vertex_x, vertex_y,
    output ready
  );
endinterface

interface prs_out_if;
  import prs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VTX_W-1:0] out_x;
  logic signed [VTX_W-1:0] out_y;
  logic                    is_vertex;
  logic                    last;

  modport source (
    output valid, out_x, out_y, is_vertex, last,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, is_vertex, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/prs_mac.sv =====
// Shared multiply-accumulate unit: one rule*diff product per cycle, registered,
// then folded into the x or y accumulator. Depends on prs_pkg.
`default_nettype none

module prs_mac (
  input  wire logic                              clk,
  input  wire prs_pkg::prs_mac_ctl_t             ctl,
  input  wire logic signed [prs_pkg::RULE_W-1:0] rx,
  input  wire logic signed [prs_pkg::RULE_W-1:0] ry,
  input  wire logic signed [prs_pkg::DIFF_W-1:0] dx,
  input  wire logic signed [prs_pkg::DIFF_W-1:0] dy,
  output logic signed [prs_pkg::RND_W-1:0]       rnd_x,
  output logic signed [prs_pkg::RND_W-1:0]       rnd_y
);
  import prs_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);

  logic signed [RULE_W-1:0] op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_x_r;
  logic signed [ACC_W-1:0]  acc_y_r;

  // operand select
  always_comb begin
    unique case (ctl.mul_term)
      TERM_XX: begin op_a = rx; op_b = dx; end
      TERM_YY: begin op_a = ry; op_b = dy; end
      TERM_XY: begin op_a = rx; op_b = dy; end
      TERM_YX: begin op_a = ry; op_b = dx; end
      default: begin op_a = rx; op_b = dx; end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod;
    end
  end

  // accumulate; the half lsb rides in with the first term so the round is a slice
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      unique case (ctl.acc_term)
        TERM_XX: acc_x_r <= prod_ext + HALF_LSB;
        TERM_YY: acc_x_r <= acc_x_r - prod_ext;
        TERM_XY: acc_y_r <= prod_ext + HALF_LSB;
        TERM_YX: acc_y_r <= acc_y_r + prod_ext;
        default: acc_x_r <= acc_x_r;
      endcase
    end
  end

  assign rnd_x = acc_x_r[ACC_W-1:FRAC_W];
  assign rnd_y = acc_y_r[ACC_W-1:FRAC_W];

endmodule

`default_nettype wire

// ===== rtl/core/polyline_rule_substitution.sv =====
// Polyline rule substitution: rule store, sequencer and output register.
// Depends on prs_pkg, prs_in_if / prs_out_if and prs_mac.
// Load item: taken on its transfer, no result. First vertex, start_req vertex or
// rule_count 0: the vertex goes straight to the output register. Other vertices:
// per inserted point a store read, 4 products through the one shared multiplier
// plus drain and an output load, then the vertex. Each output load waits while the
// output register holds a stalled result.
// Reset (synchronous, rst_n low) clears rule_count, previous vertex and control; the
// rule store is not cleared.
`default_nettype none

module polyline_rule_substitution #(
  parameter int RULE_MAX = prs_pkg::RULE_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [prs_pkg::RCNT_W-1:0]   cfg_wdata,
  prs_in_if.sink                            in_chan,
  prs_out_if.source                         out_chan
);
  import prs_pkg::*;

  localparam int CNT_W  = $clog2(RULE_MAX + 1);
  localparam int ADDR_W = (RULE_MAX > 1) ? $clog2(RULE_MAX) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_PUT,
    S_VERT
  } state_t;

  state_t                   state_r;
  logic [2:0]               ph_r;
  logic [2:0]               ph_m1;
  logic [CNT_W-1:0]         k_r;
  logic [CNT_W-1:0]         k_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_clamp;
  logic [RCNT_W-1:0]        rule_count_r;
  logic [VTX_W-1:0]         vx_r;
  logic [VTX_W-1:0]         vy_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic [VTX_W-1:0]         prev_x_r;
  logic [VTX_W-1:0]         prev_y_r;
  logic                     have_prev_r;
  logic signed [RULE_W-1:0] rx_r;
  logic signed [RULE_W-1:0] ry_r;
  logic                     out_valid_r;
  logic [VTX_W-1:0]         out_x_r;
  logic [VTX_W-1:0]         out_y_r;
  logic                     out_vtx_r;
  logic                     out_last_r;

  logic [2*RULE_W-1:0]      rule_mem [RULE_MAX];

  logic                     in_xfer;
  logic                     out_free;
  logic                     out_load;
  logic                     slot_ok;
  prs_mac_ctl_t             mac_ctl;
  logic signed [RND_W-1:0]  rnd_x;
  logic signed [RND_W-1:0]  rnd_y;
  logic [SUM_W-1:0]         sum_x;
  logic [SUM_W-1:0]         sum_y;

  // handshake
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_load      = out_free && ((state_r == S_PUT) || (state_r == S_VERT));

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_x     = out_x_r;
  assign out_chan.out_y     = out_y_r;
  assign out_chan.is_vertex = out_vtx_r;
  assign out_chan.last      = out_last_r;

  // rule count clamped to the store depth
  assign cnt_clamp = (32'(rule_count_r) > 32'(RULE_MAX)) ? CNT_W'(RULE_MAX)
                                                         : CNT_W'(rule_count_r);
  assign slot_ok   = 32'(in_chan.rule_slot) < 32'(RULE_MAX);
  assign k_nxt     = k_r + CNT_W'(1);
  assign ph_m1     = ph_r - 3'd1;

  // rule store: written by load transfers, read one slot per point
  always_ff @(posedge clk) begin
    if (in_xfer && (in_chan.func == FUNC_LOAD) && slot_ok) begin
      rule_mem[ADDR_W'(in_chan.rule_slot)] <= {in_chan.rule_x, in_chan.rule_y};
    end
    if (state_r == S_READ) begin
      {rx_r, ry_r} <= rule_mem[k_r[ADDR_W-1:0]];
    end
  end

  // mac sequencing: products in phases 0..3, accumulation one phase later
  always_comb begin
    mac_ctl.mul_en   = (state_r == S_MAC) && (ph_r < 3'd4);
    mac_ctl.mul_term = prs_term_t'(ph_r[1:0]);
    mac_ctl.acc_en   = (state_r == S_MAC) && (ph_r != 3'd0);
    mac_ctl.acc_term = prs_term_t'(ph_m1[1:0]);
  end

  prs_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .rx    (rx_r),
    .ry    (ry_r),
    .dx    (dx_r),
    .dy    (dy_r),
    .rnd_x (rnd_x),
    .rnd_y (rnd_y)
  );

  // offset by the previous vertex
  assign sum_x = {rnd_x[RND_W-1], rnd_x} + {{(SUM_W-VTX_W){prev_x_r[VTX_W-1]}}, prev_x_r};
  assign sum_y = {rnd_y[RND_W-1], rnd_y} + {{(SUM_W-VTX_W){prev_y_r[VTX_W-1]}}, prev_y_r};

  // sequencer, config register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ph_r         <= 3'd0;
      k_r          <= '0;
      cnt_r        <= '0;
      rule_count_r <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      have_prev_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        rule_count_r <= cfg_wdata;
      end
      // output register fills on a load, empties on a transfer
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_chan.func == FUNC_VERTEX)) begin
            vx_r  <= in_chan.vertex_x;
            vy_r  <= in_chan.vertex_y;
            dx_r  <= {in_chan.vertex_x[VTX_W-1], in_chan.vertex_x}
                     - {prev_x_r[VTX_W-1], prev_x_r};
            dy_r  <= {in_chan.vertex_y[VTX_W-1], in_chan.vertex_y}
                     - {prev_y_r[VTX_W-1], prev_y_r};
            k_r   <= '0;
            ph_r  <= 3'd0;
            cnt_r <= cnt_clamp;
            if (in_chan.start_req || !have_prev_r || (cnt_clamp == '0)) begin
              state_r <= S_VERT;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          ph_r    <= 3'd0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (ph_r == 3'd4) begin
            state_r <= S_PUT;
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_x_r     <= sat_vtx(sum_x);
            out_y_r     <= sat_vtx(sum_y);
            out_vtx_r   <= 1'b0;
            out_last_r  <= 1'b0;
            k_r         <= k_nxt;
            state_r     <= (k_nxt == cnt_r) ? S_VERT : S_READ;
          end
        end
        S_VERT: begin
          if (out_free) begin
            out_x_r     <= vx_r;
            out_y_r     <= vy_r;
            out_vtx_r   <= 1'b1;
            out_last_r  <= 1'b1;
            prev_x_r    <= vx_r;
            prev_y_r    <= vy_r;
            have_prev_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prs_checker.sv =====
// Port-level checks for polyline_rule_substitution, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module prs_port_checks (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_func,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_is_vertex,
  input wire logic out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // only the vertex closes an item, inserted points never do
  a_last_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_vertex == out_last))
    else $error("last flag disagrees with vertex flag");

  // while an item's points are still coming, no new item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of an item");

  // a rule load completes in its transfer cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == 1'b0) |=> in_ready)
    else $error("rule load held the block busy");

endmodule

bind polyline_rule_substitution prs_port_checks u_prs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_func       (in_chan.func),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_is_vertex (out_chan.is_vertex),
  .out_last      (out_chan.last)
);

`default_nettype wire
